@@ sv/ffba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants for the first-fit block allocator
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned BlockSlots = 64;
  localparam int unsigned AlignBytes = 32;
  localparam int unsigned SlotW      = $clog2(BlockSlots);
  localparam int unsigned AlignW     = $clog2(AlignBytes);
  localparam int unsigned AddrW      = 24;
  localparam int unsigned SizeW      = 25;
  localparam int unsigned TagW       = 16;

  localparam logic [SlotW-1:0] SlotHead     = SlotW'(0);
  localparam logic [SlotW-1:0] SlotSentinel = SlotW'(1);
  localparam logic [SlotW-1:0] SlotFirst    = SlotW'(2);
  localparam logic [SlotW-1:0] SlotLast     = SlotW'(BlockSlots - 1);
  localparam logic [SlotW:0]   WalkLimit    = (SlotW + 1)'(BlockSlots + 1);
  localparam logic [TagW-1:0]  TagNone      = 16'hFFFF;
  localparam logic [AddrW-1:0] AddrOnes     = 24'hFFFFFF;
  localparam logic [AddrW-1:0] PoolBaseRst  = 24'h808000;
  localparam logic [SizeW-1:0] PoolSizeRst  = 25'd8355840;

  typedef enum logic [2:0] {
    KindInit   = 3'd0,
    KindAlloc  = 3'd1,
    KindFree   = 3'd2,
    KindSize   = 3'd3,
    KindLookup = 3'd4,
    KindFreeTag = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoFit   = 2'd1,
    StNoSlot  = 2'd2,
    StMissing = 2'd3
  } status_e;

  localparam logic [0:0] CfgPoolBase = 1'b0;
  localparam logic [0:0] CfgPoolSize = 1'b1;

  typedef enum logic [4:0] {
    FsIdle,
    FsClear,
    FsWalkRd,
    FsWalkChk,
    FsScanSlot,
    FsSplit,
    FsExact,
    FsFreeRd,
    FsFreeNxt,
    FsFreePrv,
    FsFreeMrgN,
    FsFreeMrgP,
    FsOut
  } fsm_e;

  // walk purposes
  typedef enum logic [1:0] {
    WkFit,
    WkAddr,
    WkTag
  } walk_e;

  // controller -> datapath
  typedef struct packed {
    logic  start;        // latch request
    logic  clear_step;   // write init entry at clear counter
    logic  clear_start;
    logic  rd_cur;       // read descriptor at cur
    logic  advance;      // prev <= cur, cur <= next
    logic  rewalk;       // key <= cur address, walk again from the head
    logic  scan_step;
    logic  scan_start;
    logic  wr_split;     // write new slot, then split cur
    logic  wr_exact;
    logic  rd_next;      // read descriptor at cur.next into nx
    logic  rd_prev;      // read descriptor at prev
    logic  mrg_next;
    logic  mrg_prev;
    logic  set_free;
    logic  set_result;
    status_e res_status;
    logic  res_addr_cur;
    logic  res_size_cur;
  } ffba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  clear_done;
    logic  cur_is_sent;
    logic  walk_over;
    logic  hit_fit;
    logic  hit_addr;
    logic  hit_tag;
    logic  cur_in_use;
    logic  exact_fit;
    logic  scan_found;
    logic  scan_done;
    logic  nx_mergeable;
    logic  prv_mergeable;
  } ffba_sts_t;

endpackage

@@ sv/ffba_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_stream_if
// valid/ready channel carrying a payload of generic type
// ----------------------------------------------------------------------------
interface ffba_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/ffba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// single-port generic ram with registered read
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ sv/ffba_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_datapath
// descriptor store, walk pointers, free-slot scan and result registers
// ----------------------------------------------------------------------------
module ffba_datapath
  import ffba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffba_cmd_t        cmd_i,
  output ffba_sts_t        sts_o,
  input  kind_e            kind_i,
  input  logic [AddrW-1:0] req_size_i,
  input  logic [AddrW-1:0] block_addr_i,
  input  logic [TagW-1:0]  tag_i,
  input  logic [AddrW-1:0] pool_base_i,
  input  logic [SizeW-1:0] pool_size_i,
  output logic [AddrW-1:0] result_addr_o,
  output logic [SizeW-1:0] result_size_o,
  output status_e          result_status_o
);
  // descriptor word: in_use, tag, addr, size, next
  localparam int unsigned DescW = 1 + TagW + AddrW + SizeW + SlotW;
  typedef struct packed {
    logic             in_use;
    logic [TagW-1:0]  tag;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
    logic [SlotW-1:0] nxt;
  } desc_t;

  logic             live_q [BlockSlots];
  logic             live_d [BlockSlots];
  logic             ram_we;
  logic [SlotW-1:0] ram_addr;
  desc_t            ram_wdata, ram_rdata;

  kind_e            kind_q;
  logic [SizeW-1:0] need_q;
  logic [AddrW-1:0] key_addr_q;
  logic [TagW-1:0]  key_tag_q;
  logic [SlotW-1:0] cur_q, prev_q, slot_q;
  logic [SlotW:0]   steps_q;
  logic [SlotW:0]   clr_q;
  desc_t            cur_desc_q, nx_desc_q, prv_desc_q;
  logic [AddrW-1:0] res_addr_q;
  logic [SizeW-1:0] res_size_q;
  status_e          res_status_q;
  logic [1:0]       wr_phase_q;
  logic [SizeW-1:0] need_w;

  ffba_ram #(.Width(DescW), .Depth(BlockSlots)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign need_w = {1'b0, req_size_i} + SizeW'(AlignBytes - 1);

  // ram port multiplexing
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cur_q;
    ram_wdata = cur_desc_q;
    if (cmd_i.clear_step) begin
      ram_we   = 1'b1;
      ram_addr = clr_q[SlotW-1:0];
      ram_wdata = '{in_use: 1'b0, tag: TagNone, addr: '0, size: '0, nxt: SlotSentinel};
      if (clr_q[SlotW-1:0] == SlotHead) begin
        ram_wdata.addr = pool_base_i;
        ram_wdata.size = pool_size_i;
      end else if (clr_q[SlotW-1:0] == SlotSentinel) begin
        ram_wdata.addr   = AddrOnes;
        ram_wdata.in_use = 1'b1;
      end
    end else if (cmd_i.wr_split) begin
      ram_we = 1'b1;
      if (wr_phase_q == 2'd0) begin
        ram_addr  = slot_q;
        ram_wdata = '{in_use: 1'b0, tag: TagNone,
                      addr: cur_desc_q.addr + need_q[AddrW-1:0],
                      size: cur_desc_q.size - need_q, nxt: cur_desc_q.nxt};
      end else begin
        ram_addr  = cur_q;
        ram_wdata = '{in_use: 1'b1, tag: key_tag_q, addr: cur_desc_q.addr,
                      size: need_q, nxt: slot_q};
      end
    end else if (cmd_i.wr_exact) begin
      ram_we = 1'b1;
      ram_wdata.in_use = 1'b1;
      ram_wdata.tag    = key_tag_q;
    end else if (cmd_i.rd_next) begin
      ram_addr = cur_desc_q.nxt;
    end else if (cmd_i.rd_prev) begin
      ram_addr = prev_q;
    end else if (cmd_i.mrg_next) begin
      // absorb successor into cur
      ram_we = 1'b1;
      ram_wdata.addr = (cur_desc_q.addr > nx_desc_q.addr) ? nx_desc_q.addr
                                                          : cur_desc_q.addr;
      ram_wdata.size = cur_desc_q.size + nx_desc_q.size;
      ram_wdata.nxt  = nx_desc_q.nxt;
      ram_wdata.in_use = 1'b0;
      ram_wdata.tag    = TagNone;
    end else if (cmd_i.set_free) begin
      ram_we = 1'b1;
      ram_wdata.in_use = 1'b0;
      ram_wdata.tag    = TagNone;
    end else if (cmd_i.mrg_prev) begin
      ram_we   = 1'b1;
      ram_addr = prev_q;
      ram_wdata = prv_desc_q;
      ram_wdata.addr = (prv_desc_q.addr > cur_desc_q.addr) ? cur_desc_q.addr
                                                           : prv_desc_q.addr;
      ram_wdata.size = prv_desc_q.size + cur_desc_q.size;
      ram_wdata.nxt  = cur_desc_q.nxt;
    end else if (cmd_i.scan_step) begin
      ram_addr = cur_q;
    end
  end

  always_comb begin
    for (int i = 0; i < BlockSlots; i++) live_d[i] = live_q[i];
    if (cmd_i.clear_start) begin
      for (int i = 0; i < BlockSlots; i++) live_d[i] = 1'b0;
      live_d[SlotHead]     = 1'b1;
      live_d[SlotSentinel] = 1'b1;
    end
    if (cmd_i.wr_split && wr_phase_q == 2'd0) live_d[slot_q] = 1'b1;
    if (cmd_i.mrg_next) live_d[cur_desc_q.nxt] = 1'b0;
    if (cmd_i.mrg_prev) live_d[cur_q] = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BlockSlots; i++) live_q[i] <= 1'b0;
      clr_q      <= '0;
      wr_phase_q <= '0;
    end else begin
      for (int i = 0; i < BlockSlots; i++) live_q[i] <= live_d[i];
      if (cmd_i.clear_start) clr_q <= '0;
      else if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.wr_split) wr_phase_q <= wr_phase_q + 1'b1;
      else wr_phase_q <= '0;
    end
  end

  // request, walk pointers and descriptor snapshots
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q     <= kind_i;
      need_q     <= {need_w[SizeW-1:AlignW], AlignW'(0)};
      key_addr_q <= block_addr_i;
      key_tag_q  <= tag_i;
      cur_q      <= SlotHead;
      prev_q     <= SlotHead;
      steps_q    <= '0;
    end
    if (cmd_i.rd_cur) cur_desc_q <= ram_rdata;
    if (cmd_i.advance) begin
      prev_q  <= cur_q;
      cur_q   <= cur_desc_q.nxt;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.rewalk) begin
      key_addr_q <= cur_desc_q.addr;
      cur_q      <= SlotHead;
      prev_q     <= SlotHead;
      steps_q    <= '0;
    end
    if (cmd_i.scan_start) slot_q <= SlotFirst;
    else if (cmd_i.scan_step && !sts_o.scan_found) slot_q <= slot_q + 1'b1;
    if (cmd_i.rd_next) nx_desc_q <= ram_rdata;
    if (cmd_i.rd_prev) prv_desc_q <= ram_rdata;
    if (cmd_i.mrg_next) begin
      cur_desc_q.addr <= ram_wdata.addr;
      cur_desc_q.size <= ram_wdata.size;
      cur_desc_q.nxt  <= ram_wdata.nxt;
    end
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.res_status;
      res_addr_q   <= cmd_i.res_addr_cur ? cur_desc_q.addr : '0;
      res_size_q   <= cmd_i.res_size_cur ? cur_desc_q.size : '0;
    end
  end

  // the free-by-tag path reuses the address key once the block is found
  assign sts_o.clear_done   = (clr_q == (SlotW + 1)'(BlockSlots - 1));
  assign sts_o.cur_is_sent  = (cur_q == SlotSentinel);
  assign sts_o.walk_over    = (steps_q == WalkLimit);
  assign sts_o.hit_fit      = !cur_desc_q.in_use && cur_desc_q.size >= need_q;
  assign sts_o.hit_addr     = cur_desc_q.addr == key_addr_q;
  assign sts_o.hit_tag      = cur_desc_q.tag == key_tag_q &&
                              (kind_q == KindFreeTag || cur_desc_q.in_use);
  assign sts_o.cur_in_use   = cur_desc_q.in_use;
  assign sts_o.exact_fit    = cur_desc_q.size == need_q && prev_q != cur_q;
  assign sts_o.scan_found   = !live_q[slot_q];
  assign sts_o.scan_done    = slot_q == SlotLast;
  assign sts_o.nx_mergeable = cur_desc_q.nxt != SlotSentinel && !nx_desc_q.in_use;
  assign sts_o.prv_mergeable = prev_q != cur_q && !prv_desc_q.in_use;

  assign result_addr_o   = res_addr_q;
  assign result_size_o   = res_size_q;
  assign result_status_o = res_status_q;
endmodule

@@ sv/ffba_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// operation sequencer for the block allocator
// ----------------------------------------------------------------------------
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  kind_e     in_kind_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ffba_cmd_t cmd_o,
  input  ffba_sts_t sts_i
);
  fsm_e  state_q, state_d;
  kind_e kind_q;
  walk_e walk_q, walk_d;
  logic  rd_wait_q, rd_wait_d;
  logic  tagged_q, tagged_d;
  logic  scan_wait_q;
  logic  split_two_q;
  logic  boot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsClear;
      kind_q      <= KindInit;
      walk_q      <= WkFit;
      rd_wait_q   <= 1'b0;
      tagged_q    <= 1'b0;
      scan_wait_q <= 1'b0;
      split_two_q <= 1'b0;
      boot_q      <= 1'b1;
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      rd_wait_q <= rd_wait_d;
      tagged_q  <= tagged_d;
      if (state_q == FsIdle && in_valid_i) kind_q <= in_kind_i;
      scan_wait_q <= (state_q == FsScanSlot);
      split_two_q <= (state_q == FsSplit) && !split_two_q;
      if (state_q == FsClear && sts_i.clear_done) boot_q <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    rd_wait_d = 1'b0;
    tagged_d  = tagged_q;
    unique case (state_q)
      FsIdle: begin
        if (in_valid_i) begin
          tagged_d = 1'b0;
          unique case (in_kind_i)
            KindInit: state_d = FsClear;
            KindAlloc: begin
              walk_d = WkFit;
              state_d = FsWalkRd;
            end
            KindFree, KindSize: begin
              walk_d = WkAddr;
              state_d = FsWalkRd;
            end
            KindLookup, KindFreeTag: begin
              walk_d = WkTag;
              state_d = FsWalkRd;
            end
            default: state_d = FsOut;
          endcase
        end
      end
      // the pass after reset gives no beat
      FsClear: if (sts_i.clear_done) state_d = boot_q ? FsIdle : FsOut;
      FsWalkRd: begin
        rd_wait_d = 1'b1;
        if (rd_wait_q) state_d = FsWalkChk;
        else if (sts_i.cur_is_sent || sts_i.walk_over) state_d = FsOut;
      end
      FsWalkChk: begin
        if ((walk_q == WkFit && sts_i.hit_fit) ||
            (walk_q == WkAddr && sts_i.hit_addr) ||
            (walk_q == WkTag && sts_i.hit_tag)) begin
          if (walk_q == WkFit) state_d = sts_i.exact_fit ? FsExact : FsScanSlot;
          else if (walk_q == WkTag && kind_q == KindLookup) state_d = FsOut;
          else if (walk_q == WkTag) begin
            // free by tag: restart an address walk for the found block
            tagged_d = 1'b1;
            walk_d   = WkAddr;
            state_d  = FsWalkRd;
          end
          else if (kind_q == KindSize) state_d = FsOut;
          else state_d = FsFreeRd;
        end else begin
          state_d = FsWalkRd;
        end
      end
      FsScanSlot: begin
        if (scan_wait_q && sts_i.scan_found) state_d = FsSplit;
        else if (scan_wait_q && sts_i.scan_done) state_d = FsOut;
      end
      FsSplit: if (split_two_q) state_d = FsOut;
      FsExact: state_d = FsOut;
      FsFreeRd: state_d = sts_i.cur_in_use ? FsFreeNxt : FsOut;
      FsFreeNxt: begin
        rd_wait_d = !rd_wait_q;
        if (rd_wait_q) state_d = FsFreeMrgN;
      end
      FsFreeMrgN: begin
        rd_wait_d = 1'b1;
        if (rd_wait_q) state_d = FsFreePrv;
      end
      FsFreePrv: state_d = FsFreeMrgP;
      FsFreeMrgP: state_d = FsOut;
      FsOut: if (out_ready_i) state_d = FsIdle;
      default: state_d = FsIdle;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.res_status = StOk;
    in_ready_o  = (state_q == FsIdle);
    out_valid_o = 1'b0;
    unique case (state_q)
      FsIdle: begin
        cmd_o.start = in_valid_i;
        if (in_valid_i && in_kind_i == KindInit) cmd_o.clear_start = 1'b1;
        if (in_valid_i && !(in_kind_i inside {KindInit, KindAlloc, KindFree,
                                              KindSize, KindLookup, KindFreeTag})) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = StMissing;
        end
      end
      FsClear: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = StOk;
        end
      end
      FsWalkRd: begin
        cmd_o.rd_cur = rd_wait_q;
        if (!rd_wait_q && (sts_i.cur_is_sent || sts_i.walk_over)) begin
          cmd_o.set_result = 1'b1;
          unique case (walk_q)
            WkFit:   cmd_o.res_status = StNoFit;
            default: cmd_o.res_status = StMissing;
          endcase
        end
      end
      FsWalkChk: begin
        if (!((walk_q == WkFit && sts_i.hit_fit) ||
              (walk_q == WkAddr && sts_i.hit_addr) ||
              (walk_q == WkTag && sts_i.hit_tag))) begin
          cmd_o.advance = 1'b1;
        end else if (walk_q == WkFit) begin
          cmd_o.scan_start = !sts_i.exact_fit;
        end else if (walk_q == WkTag && kind_q == KindLookup) begin
          cmd_o.set_result   = 1'b1;
          cmd_o.res_addr_cur = 1'b1;
        end else if (walk_q == WkTag) begin
          cmd_o.rewalk = 1'b1;
        end else if (kind_q == KindSize) begin
          cmd_o.set_result   = 1'b1;
          cmd_o.res_size_cur = 1'b1;
        end
      end
      FsScanSlot: begin
        cmd_o.scan_step = scan_wait_q;
        if (scan_wait_q && !sts_i.scan_found && sts_i.scan_done) begin
          cmd_o.set_result = 1'b1;
          cmd_o.res_status = StNoSlot;
        end
      end
      FsSplit: begin
        cmd_o.wr_split = 1'b1;
        if (split_two_q) begin
          cmd_o.set_result   = 1'b1;
          cmd_o.res_addr_cur = 1'b1;
        end
      end
      FsExact: begin
        cmd_o.wr_exact     = 1'b1;
        cmd_o.set_result   = 1'b1;
        cmd_o.res_addr_cur = 1'b1;
      end
      FsFreeRd: begin
        cmd_o.set_result   = 1'b1;
        cmd_o.res_addr_cur = tagged_q;
        cmd_o.res_status   = sts_i.cur_in_use ? StOk : StMissing;
      end
      FsFreeNxt: begin
        cmd_o.rd_next = 1'b1;
      end
      FsFreeMrgN: begin
        if (!rd_wait_q) begin
          if (sts_i.nx_mergeable) cmd_o.mrg_next = 1'b1;
          else cmd_o.set_free = 1'b1;
        end else begin
          cmd_o.rd_prev = 1'b1;
        end
      end
      FsFreePrv: cmd_o.rd_prev = 1'b1;
      FsFreeMrgP: cmd_o.mrg_prev = sts_i.prv_mergeable;
      FsOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

@@ sv/first_fit_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit allocator over a linked table of block descriptors
// ----------------------------------------------------------------------------
// usage
//   req_if carries one request beat (kind, req_size, block_addr, tag);
//   rsp_if returns exactly one beat (result_addr, result_size, status).
//   cfg_we_i/cfg_idx_i/cfg_data_i write pool_base and pool_size, which
//   take effect on the next init request.
// operation
//   one request at a time; the list walk reads and checks each descriptor
//   in turn through the single port of the descriptor ram. An unknown kind
//   is answered without a walk. A split adds the free-slot scan, a free
//   adds the merge with its neighbours, free by tag adds a second walk, and
//   init rewrites every row of the descriptor ram.
// reset
//   after reset the unit runs an init pass over all 64 ram rows, one row a
//   cycle, before it takes its first request; that pass gives no beat.
// stall
//   a result waits in its register until rsp_if is ready; no request is
//   taken while it waits.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit
  import ffba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ffba_stream_if.sink      req_if,
  ffba_stream_if.source    rsp_if,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i
);
  ffba_cmd_t        cmd;
  ffba_sts_t        sts;
  logic [AddrW-1:0] pool_base_q;
  logic [SizeW-1:0] pool_size_q;
  status_e          res_status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= PoolBaseRst;
      pool_size_q <= PoolSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgPoolBase: pool_base_q <= cfg_data_i[AddrW-1:0];
        CfgPoolSize: pool_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .in_kind_i   (kind_e'(req_if.data.kind)),
    .out_valid_o (rsp_if.valid),
    .out_ready_i (rsp_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ffba_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_e'(req_if.data.kind)),
    .req_size_i      (req_if.data.req_size),
    .block_addr_i    (req_if.data.block_addr),
    .tag_i           (req_if.data.tag),
    .pool_base_i     (pool_base_q),
    .pool_size_i     (pool_size_q),
    .result_addr_o   (rsp_if.data.result_addr),
    .result_size_o   (rsp_if.data.result_size),
    .result_status_o (res_status)
  );

  assign rsp_if.data.status = res_status;

  // never offer a result and take a request in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsp_if.valid && req_if.ready))
    else $error("request taken while a result is pending");

  // a result that was not taken is still offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_if.valid && !rsp_if.ready |=> rsp_if.valid)
    else $error("result dropped under stall");
endmodule
